// File: hdl/sorted_table_binary_search_unit_defines.svh
// Assertion macros for the checker file of the sorted table search unit
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbs assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbs assertion failed");

`endif

// File: hdl/stbs_pkg.sv
// Package: types and constants of the sorted table search unit
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Input beat
  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } in_t;

  // Result beat
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_index;
    logic [CNT_W-1:0] entry_count;
    logic             overflow;
  } out_t;

  // Table memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

// File: hdl/sorted_table_binary_search_unit.sv
// Top level of the sorted table search unit
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (op, value)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (found, hit_index,
//          |           |                       |   entry_count, overflow)
//
// One item at a time. Clear and unused ops go through ST_RESP to the result register.
// Insert walks down the table one entry per cycle through the RAM read port,
// moving each entry above the key up by one, then writes the key below them.
// Search issues each probe in ST_SRCH_RD and compares the read data in ST_SRCH_CMP.
// Reset clears the entry count and control only; the table needs no clearing.
// A new item is taken while the previous result still waits on out_ready_i.
module sorted_table_binary_search_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stbs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output stbs_pkg::out_t out_data_o
);
  import stbs_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // Sequencer
  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Sorted entry store
  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: hdl/stbs_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle
module stbs_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/stbs_ctrl.sv
// Sequencer: clear, ordered insert by shifting, binary search, result register
module stbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stbs_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stbs_pkg::out_t    out_data_o,
  output stbs_pkg::ram_req_t ram_req_o,
  input  logic [31:0]       ram_rdata_i
);
  import stbs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INS      = 6'b000010,
    ST_INS_KEY  = 6'b000100,
    ST_SRCH_RD  = 6'b001000,
    ST_SRCH_CMP = 6'b010000,
    ST_RESP     = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [31:0] key_q, key_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   low_q, low_d;
  logic [CNT_W-1:0]   high1_q, high1_d;   // upper search bound plus one
  logic [IDX_W-1:0]   mid_q, mid_d;
  out_t               res_q, res_d;
  out_t               out_q;
  logic               out_valid_q, out_valid_d;
  logic               load_out;
  logic [CNT_W:0]     mid_sum;
  logic signed [31:0] probe;
  ram_req_t           req;

  assign probe   = $signed(ram_rdata_i);
  assign mid_sum = {1'b0, low_q} + {1'b0, high1_q} - {{CNT_W{1'b0}}, 1'b1};

  // Next-state logic
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    key_d    = key_q;
    pos_d    = pos_q;
    low_d    = low_q;
    high1_d  = high1_q;
    mid_d    = mid_q;
    res_d    = res_q;
    load_out = 1'b0;
    req      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d             = in_data_i.value;
          res_d.found       = 1'b0;
          res_d.hit_index   = '0;
          res_d.entry_count = count_q;
          res_d.overflow    = 1'b0;
          unique case (in_data_i.op)
            OP_CLEAR: begin
              count_d           = '0;
              res_d.entry_count = '0;
              state_d           = ST_RESP;
            end
            OP_INSERT: begin
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                res_d.overflow = 1'b1;
                state_d        = ST_RESP;
              end else if (count_q == '0) begin
                // empty table: key goes straight to entry zero
                req.we            = 1'b1;
                req.waddr         = '0;
                req.wdata         = in_data_i.value;
                count_d           = CNT_W'(1);
                res_d.entry_count = CNT_W'(1);
                state_d           = ST_RESP;
              end else begin
                // start the shift from the top entry
                req.re    = 1'b1;
                req.raddr = count_q[IDX_W-1:0] - IDX_W'(1);
                pos_d     = count_q[IDX_W-1:0];
                state_d   = ST_INS;
              end
            end
            OP_SEARCH: begin
              low_d   = '0;
              high1_d = count_q;
              state_d = ST_SRCH_RD;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Read data holds entry pos-1; larger entries move up by one
      ST_INS: begin
        req.we    = 1'b1;
        req.waddr = pos_q;
        if (probe > key_q) begin
          req.wdata = ram_rdata_i;
          if (pos_q == IDX_W'(1)) begin
            pos_d   = '0;
            state_d = ST_INS_KEY;
          end else begin
            req.re    = 1'b1;
            req.raddr = pos_q - IDX_W'(2);
            pos_d     = pos_q - IDX_W'(1);
          end
        end else begin
          req.wdata         = key_q;
          count_d           = count_q + CNT_W'(1);
          res_d.entry_count = count_q + CNT_W'(1);
          state_d           = ST_RESP;
        end
      end

      // Every entry was larger: key lands at the bottom
      ST_INS_KEY: begin
        req.we            = 1'b1;
        req.waddr         = pos_q;
        req.wdata         = key_q;
        count_d           = count_q + CNT_W'(1);
        res_d.entry_count = count_q + CNT_W'(1);
        state_d           = ST_RESP;
      end

      // Issue the probe at the midpoint, or give up on an empty range
      ST_SRCH_RD: begin
        if (low_q < high1_q) begin
          mid_d     = mid_sum[IDX_W:1];
          req.re    = 1'b1;
          req.raddr = mid_sum[IDX_W:1];
          state_d   = ST_SRCH_CMP;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_SRCH_CMP: begin
        if (probe == key_q) begin
          res_d.found     = 1'b1;
          res_d.hit_index = mid_q;
          state_d         = ST_RESP;
        end else begin
          if (key_q > probe) begin
            low_d = {1'b0, mid_q} + CNT_W'(1);
          end else begin
            high1_d = {1'b0, mid_q};
          end
          state_d = ST_SRCH_RD;
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    pos_q   <= pos_d;
    low_q   <= low_d;
    high1_q <= high1_d;
    mid_q   <= mid_d;
    res_q   <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign ram_req_o   = req;

endmodule

// File: hdl/stbs_checker.sv
// Port-level checker for the sorted table search unit, bound to the top level
`include "sorted_table_binary_search_unit_defines.svh"

module stbs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input stbs_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input stbs_pkg::out_t out_data_o
);
  import stbs_pkg::*;

  // A waiting input beat holds
  `STBS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i))

  // A stalled result beat holds
  `STBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // A search hit never comes with a refused insert
  `STBS_ASSERT_NOW(a_hit_no_ovf, clk_i, rst_ni, out_valid_o, !(out_data_o.found && out_data_o.overflow))

  // Index is zero unless the search hit
  `STBS_ASSERT_NOW(a_idx_zero, clk_i, rst_ni, out_valid_o && !out_data_o.found, out_data_o.hit_index == '0)

  // A refused insert means the table is full
  `STBS_ASSERT_NOW(a_ovf_full, clk_i, rst_ni, out_valid_o && out_data_o.overflow, out_data_o.entry_count == CNT_W'(TABLE_DEPTH))

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
